[rtl/sobel_3d_volume_normals_unit_macros.svh]
// ----------------------------------------------------------------------------
// sobel 3d volume normals unit assertion macros
// shared property wrappers for the rtl checks
// ----------------------------------------------------------------------------
`ifndef SOBEL_3D_VOLUME_NORMALS_UNIT_MACROS_SVH
`define SOBEL_3D_VOLUME_NORMALS_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SBN_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SBN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sbn_pkg.sv]
// ----------------------------------------------------------------------------
// sbn package
// states, result struct and fixed constants of the normals unit
// ----------------------------------------------------------------------------
package sbn_pkg;

   localparam int CFG_W       = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int POS_W       = 5;
   localparam int NMAG_W      = 15;
   localparam int NORM_W      = 16;
   localparam int NORM_ONE    = 16384;
   localparam int FRAC_BITS   = 14;
   localparam int MSQ_W       = 30;
   localparam int PROD_W      = 2 * MSQ_W;
   localparam int T_W         = 62;
   localparam int K_MAX       = 31;
   localparam int K_W         = 5;
   localparam int ROOT_W      = 31;
   localparam int MK_W        = MSQ_W + K_MAX;
   localparam int NUM_W       = MK_W + FRAC_BITS + 1;
   localparam int REM_W       = 35;
   localparam int DIV_STEPS   = 15;
   localparam int STEP_W      = 5;

   localparam logic [CFG_W-1:0]     SIZE_RESET  = 6'd32;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z  = 2'd2;
   localparam logic                 FUNC_LOAD   = 1'b0;
   localparam logic                 FUNC_NORMAL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_READ,
      ST_DRAIN,
      ST_KICK,
      ST_WAIT,
      ST_DONE
   } sbn_state_type;

   typedef enum logic [2:0] {
      NS_IDLE,
      NS_SHIFT,
      NS_MUL,
      NS_SCALE,
      NS_SQRT,
      NS_DIVLD,
      NS_DIV,
      NS_DONE
   } sbn_nstate_type;

   typedef struct packed {
      logic start;
   } sbn_ctl_type;

   typedef struct packed {
      logic                   done;
      logic [2:0]             neg;
      logic [2:0][NMAG_W-1:0] mag;
   } sbn_res_type;

endpackage

[rtl/sbn_ram.sv]
// ----------------------------------------------------------------------------
// sbn ram
// generic simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
module sbn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/sbn_csub.sv]
// ----------------------------------------------------------------------------
// sbn compare subtract
// shared compare and subtract step for square root and division
// ----------------------------------------------------------------------------
module sbn_csub
   import sbn_pkg::*;
#(
   parameter int W = 35
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic         ge,
   output logic [W-1:0] diff
);

   logic [W:0] sub;

   assign sub  = {1'b0, a} - {1'b0, b};
   assign ge   = ~sub[W];
   assign diff = sub[W-1:0];

endmodule

[rtl/sbn_norm.sv]
// ----------------------------------------------------------------------------
// sbn normalizer
// turns a gradient into a q1.14 unit normal: squares, root, divisions
// ----------------------------------------------------------------------------
module sbn_norm
   import sbn_pkg::*;
#(
   parameter int GW = 21
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sbn_ctl_type          ctl,
   input  logic signed [GW-1:0] grad [3],
   output sbn_res_type          res
);

   localparam int MWID = GW - 1;
   localparam int XW   = (MWID > 31) ? MWID : 31;

   sbn_nstate_type nst_ff, nst_in;
   logic [2:0]        neg_ff, neg_in;
   logic [MWID-1:0]   mag_ff [3];
   logic [MWID-1:0]   mag_in [3];
   logic [1:0]        idx_ff, idx_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [T_W-1:0]    t_ff, t_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [MK_W-1:0]   mk_ff [3];
   logic [MK_W-1:0]   mk_in [3];
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIV_STEPS-1:0] low_ff, low_in;
   logic [NMAG_W-1:0] q_ff, q_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [2:0][NMAG_W-1:0] n_ff, n_in;

   logic [XW-1:0]     mag_x [3];
   logic [MSQ_W-1:0]  m30 [3];
   logic [MSQ_W-1:0]  mop;
   logic              big;
   logic [REM_W-1:0]  cs_a, cs_b, cs_diff;
   logic              cs_ge;
   logic [NUM_W-1:0]  num;
   logic [MK_W-1:0]   mk_sel;
   logic [NMAG_W-1:0] q_next;

   always_comb begin
      big = 1'b0;
      for (int i = 0; i < 3; i++) begin
         mag_x[i] = XW'(mag_ff[i]);
         m30[i]   = mag_x[i][MSQ_W-1:0];
         big      = big | ((mag_x[i] >> MSQ_W) != '0);
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    mop = m30[0];
         2'd1:    mop = m30[1];
         2'd2:    mop = m30[2];
         default: mop = '0;
      endcase
      case (idx_ff)
         2'd0:    mk_sel = mk_ff[0];
         2'd1:    mk_sel = mk_ff[1];
         default: mk_sel = mk_ff[2];
      endcase
   end

   assign num = NUM_W'({mk_sel, {FRAC_BITS{1'b0}}}) + NUM_W'(root_ff >> 1);

   // shared step: trial subtract of the root digit or the divisor
   always_comb begin
      if (nst_ff == NS_SQRT) begin
         cs_a = {rem_ff[REM_W-3:0], t_ff[T_W-1 -: 2]};
         cs_b = {2'b00, root_ff, 2'b01};
      end else begin
         cs_a = {rem_ff[REM_W-2:0], low_ff[DIV_STEPS-1]};
         cs_b = REM_W'(root_ff);
      end
   end

   sbn_csub #(.W(REM_W)) u_csub (
      .a    (cs_a),
      .b    (cs_b),
      .ge   (cs_ge),
      .diff (cs_diff)
   );

   assign q_next = {q_ff[NMAG_W-2:0], cs_ge};

   always_comb begin
      nst_in  = nst_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      idx_in  = idx_ff;
      prod_in = prod_ff;
      t_in    = t_ff;
      k_in    = k_ff;
      mk_in   = mk_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      step_in = step_ff;
      n_in    = n_ff;
      case (nst_ff)
         NS_IDLE: begin
            if (ctl.start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = ~grad[i][GW-1];
                  if (grad[i] == '0) begin
                     mag_in[i] = MWID'(1);
                  end else if (grad[i][GW-1]) begin
                     mag_in[i] = MWID'(-grad[i]);
                  end else begin
                     mag_in[i] = MWID'(grad[i]);
                  end
               end
               nst_in = NS_SHIFT;
            end
         end
         NS_SHIFT: begin
            if (big) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] >> 1;
               end
            end else begin
               idx_in = 2'd0;
               t_in   = '0;
               nst_in = NS_MUL;
            end
         end
         NS_MUL: begin
            prod_in = mop * mop;
            if (idx_ff != 2'd0) begin
               t_in = t_ff + T_W'(prod_ff);
            end
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               k_in = '0;
               for (int i = 0; i < 3; i++) begin
                  mk_in[i] = MK_W'(m30[i]);
               end
               nst_in = NS_SCALE;
            end
         end
         NS_SCALE: begin
            if ((k_ff != K_W'(K_MAX)) && (t_ff[T_W-1 -: 2] == 2'b00)) begin
               t_in = t_ff << 2;
               k_in = k_ff + K_W'(1);
               for (int i = 0; i < 3; i++) begin
                  mk_in[i] = mk_ff[i] << 1;
               end
            end else begin
               root_in = '0;
               rem_in  = '0;
               step_in = '0;
               nst_in  = NS_SQRT;
            end
         end
         NS_SQRT: begin
            rem_in  = cs_ge ? cs_diff : cs_a;
            root_in = {root_ff[ROOT_W-2:0], cs_ge};
            t_in    = t_ff << 2;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               idx_in = 2'd0;
               nst_in = NS_DIVLD;
            end
         end
         NS_DIVLD: begin
            rem_in  = REM_W'(num >> DIV_STEPS);
            low_in  = num[DIV_STEPS-1:0];
            q_in    = '0;
            step_in = '0;
            nst_in  = NS_DIV;
         end
         NS_DIV: begin
            rem_in  = cs_ge ? cs_diff : cs_a;
            low_in  = low_ff << 1;
            q_in    = q_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               n_in[idx_ff] = (q_next > NMAG_W'(NORM_ONE)) ? NMAG_W'(NORM_ONE) : q_next;
               idx_in = idx_ff + 2'd1;
               nst_in = (idx_ff == 2'd2) ? NS_DONE : NS_DIVLD;
            end
         end
         NS_DONE: begin
            nst_in = NS_IDLE;
         end
         default: begin
            nst_in = NS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nst_ff <= NS_IDLE;
      end else begin
         nst_ff <= nst_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      idx_ff  <= idx_in;
      prod_ff <= prod_in;
      t_ff    <= t_in;
      k_ff    <= k_in;
      mk_ff   <= mk_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      n_ff    <= n_in;
   end

   assign res.done = (nst_ff == NS_DONE);
   assign res.neg  = neg_ff;
   assign res.mag  = n_ff;

endmodule

[rtl/sobel_3d_volume_normals_unit.sv]
// ----------------------------------------------------------------------------
// sobel 3d volume normals unit
// signed-distance voxel store with a 3d sobel unit-normal engine
// ----------------------------------------------------------------------------
// A load word (tuser 0) writes one Q8.8 distance into the voxel store at the
// clamped position. A compute word (tuser 1) sweeps the 3x3x3 edge-replicated
// neighborhood through the single read port of the store (27 reads plus a
// drain state), then hands the gradient to a normalizer built around one
// shared compare-subtract unit: squares through one 30x30 multiplier, up to
// 31 steps of range scaling, a 31-step square root and three 15-step
// divisions; the square root and divider steps dominate the compute time.
// The block takes one word at a time; a finished normal sits in the output
// register until it is taken, and the next word may be accepted meanwhile.
// The store is not cleared: only voxels written since reset may be read.
// The user must write size registers only while the block is idle; the
// block itself does not enforce this. A zero size acts as 1, a size above
// DIM_MAX as DIM_MAX.
// ----------------------------------------------------------------------------
`include "sobel_3d_volume_normals_unit_macros.svh"

module sobel_3d_volume_normals_unit
   import sbn_pkg::*;
#(
   parameter int DIM_MAX    = 32,
   parameter int VALUE_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request words
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // pos_x[4:0], pos_y[9:5], pos_z[14:10], voxel_value above, zero padded
   input  logic [((3*POS_W+VALUE_BITS+7)/8)*8-1:0] req_tdata,
   // func: 0 load voxel, 1 compute normal
   input  logic                                    req_tuser,
   // result words
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // normal_x[15:0], normal_y[31:16], normal_z[47:32]
   output logic [3*NORM_W-1:0]                     rsp_tdata,
   // size register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [CSR_IDX_W-1:0]                    csr_index,
   input  logic [CFG_W-1:0]                        csr_wdata
);

   // coordinate, compare, address and accumulator widths
   localparam int CW    = $clog2(DIM_MAX);
   localparam int SW    = $clog2(DIM_MAX + 1);
   localparam int EW    = ((SW > CFG_W) ? SW : CFG_W) + 1;
   localparam int AW    = 3 * CW;
   localparam int DEPTH = 2 ** AW;
   localparam int GW    = VALUE_BITS + 5;

   sbn_state_type state_ff, state_in;

   // size registers
   logic [CFG_W-1:0] size_ff [3];
   logic [EW-1:0]    lim [3];

   // current request
   logic [EW-1:0]         pc_ff [3];
   logic [EW-1:0]         pc_in [3];
   logic [VALUE_BITS-1:0] val_ff, val_in;

   // neighborhood sweep counters and their read-aligned copies
   logic [1:0] o_ff [3];
   logic [1:0] o_in [3];
   logic [1:0] od_ff [3];
   logic [1:0] od_in [3];
   logic       rv_ff, rv_in;

   // gradient accumulators
   logic signed [GW-1:0] acc_ff [3];
   logic signed [GW-1:0] acc_in [3];

   // output register
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [3*NORM_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   logic                  req_fire;
   logic [EW-1:0]         pos_in [3];
   logic [EW-1:0]         nb [3];
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [VALUE_BITS-1:0] ram_rdata;
   logic signed [GW-1:0]  vext;
   logic [1:0]            sh [3];
   logic                  mid [3];
   sbn_ctl_type           norm_ctl;
   sbn_res_type           norm_res;
   logic [NORM_W-1:0]     nval [3];

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // effective limits: size minus one, with zero and oversize folded in
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (size_ff[i] == '0) begin
            lim[i] = '0;
         end else if (EW'(size_ff[i]) > EW'(DIM_MAX)) begin
            lim[i] = EW'(DIM_MAX - 1);
         end else begin
            lim[i] = EW'(size_ff[i]) - EW'(1);
         end
      end
   end

   assign pos_in[0] = EW'(req_tdata[POS_W-1:0]);
   assign pos_in[1] = EW'(req_tdata[2*POS_W-1:POS_W]);
   assign pos_in[2] = EW'(req_tdata[3*POS_W-1:2*POS_W]);

   // neighbor coordinate with edge replication
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (o_ff[i])
            2'd0:    nb[i] = (pc_ff[i] == '0) ? pc_ff[i] : pc_ff[i] - EW'(1);
            2'd2:    nb[i] = (pc_ff[i] == lim[i]) ? pc_ff[i] : pc_ff[i] + EW'(1);
            default: nb[i] = pc_ff[i];
         endcase
      end
   end

   assign ram_raddr = {nb[2][CW-1:0], nb[1][CW-1:0], nb[0][CW-1:0]};
   assign ram_waddr = {pc_ff[2][CW-1:0], pc_ff[1][CW-1:0], pc_ff[0][CW-1:0]};
   assign ram_we    = (state_ff == ST_LOAD);

   sbn_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (val_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // smoothing weight 2 at the center tap is a shift by one per cross axis
   assign vext = {{(GW-VALUE_BITS){ram_rdata[VALUE_BITS-1]}}, ram_rdata};
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mid[i] = (od_ff[i] == 2'd1);
      end
      sh[0] = {1'b0, mid[1]} + {1'b0, mid[2]};
      sh[1] = {1'b0, mid[2]} + {1'b0, mid[0]};
      sh[2] = {1'b0, mid[0]} + {1'b0, mid[1]};
   end

   assign norm_ctl.start = (state_ff == ST_KICK);

   sbn_norm #(.GW(GW)) u_norm (
      .clock (clock),
      .reset (reset),
      .ctl   (norm_ctl),
      .grad  (acc_ff),
      .res   (norm_res)
   );

   // sign opposite to the gradient
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nval[i] = norm_res.neg[i] ? NORM_W'(-{1'b0, norm_res.mag[i]})
                                   : {1'b0, norm_res.mag[i]};
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      val_in        = val_ff;
      o_in          = o_ff;
      od_in         = o_ff;
      rv_in         = 1'b0;
      acc_in        = acc_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      // low tap adds, high tap subtracts, center tap of the own axis drops out
      if (rv_ff) begin
         for (int a = 0; a < 3; a++) begin
            if (od_ff[a] == 2'd0) begin
               acc_in[a] = acc_ff[a] + (vext <<< sh[a]);
            end else if (od_ff[a] == 2'd2) begin
               acc_in[a] = acc_ff[a] - (vext <<< sh[a]);
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               for (int i = 0; i < 3; i++) begin
                  pc_in[i] = (pos_in[i] > lim[i]) ? lim[i] : pos_in[i];
                  o_in[i]  = 2'd0;
                  acc_in[i] = '0;
               end
               val_in   = req_tdata[3*POS_W+VALUE_BITS-1:3*POS_W];
               state_in = (req_tuser == FUNC_LOAD) ? ST_LOAD : ST_READ;
            end
         end
         ST_LOAD: begin
            state_in = ST_IDLE;
         end
         ST_READ: begin
            rv_in = 1'b1;
            if (o_ff[0] != 2'd2) begin
               o_in[0] = o_ff[0] + 2'd1;
            end else begin
               o_in[0] = 2'd0;
               if (o_ff[1] != 2'd2) begin
                  o_in[1] = o_ff[1] + 2'd1;
               end else begin
                  o_in[1] = 2'd0;
                  if (o_ff[2] != 2'd2) begin
                     o_in[2] = o_ff[2] + 2'd1;
                  end else begin
                     o_in[2] = 2'd0;
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_KICK;
         end
         ST_KICK: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (norm_res.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {nval[2], nval[1], nval[0]};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         rv_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rv_ff         <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff        <= pc_in;
      val_ff       <= val_in;
      o_ff         <= o_in;
      od_ff        <= od_in;
      acc_ff       <= acc_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[0] <= SIZE_RESET;
         size_ff[1] <= SIZE_RESET;
         size_ff[2] <= SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SIZE_X: size_ff[0] <= csr_wdata;
            CSR_SIZE_Y: size_ff[1] <= csr_wdata;
            CSR_SIZE_Z: size_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // checks
   `SBN_ASSERT_NOW(a_done_in_wait, clock, reset, norm_res.done, state_ff == ST_WAIT,
      "normalizer finished outside the wait state")
   `SBN_ASSERT_NEXT(a_load_path, clock, reset, req_fire && (req_tuser == FUNC_LOAD),
      state_ff == ST_LOAD, "load word did not go to the write state")
   `SBN_ASSERT_NOW(a_sweep_range, clock, reset, state_ff == ST_READ,
      (o_ff[0] != 2'd3) && (o_ff[1] != 2'd3) && (o_ff[2] != 2'd3),
      "neighborhood counter out of range")
   `SBN_ASSERT_NOW(a_rsp_source, clock, reset, $rose(rsp_tvalid_ff),
      $past(state_ff) == ST_DONE, "result word raised outside the done state")
   `SBN_ASSERT_NOW(a_clamped, clock, reset, state_ff == ST_READ,
      (pc_ff[0] <= lim[0]) && (pc_ff[1] <= lim[1]) && (pc_ff[2] <= lim[2]),
      "center voxel beyond the configured size")

endmodule

[test/sobel_3d_volume_normals_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel 3d volume normals checker
// watches the request, result and size register channels, keeps its own
// voxel store and size registers, predicts each unit normal and compares
// ----------------------------------------------------------------------------
module sobel_3d_volume_normals_checker
   import sbn_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [31:0]          req_tdata,
   input  logic                 req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [3*NORM_W-1:0]  rsp_tdata,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output int                   normals_pending,
   output int                   error_count
);

   typedef struct packed {
      logic [NORM_W-1:0] nz;
      logic [NORM_W-1:0] ny;
      logic [NORM_W-1:0] nx;
   } normal_word_t;

   logic signed [15:0] voxel_mem [0:32767];
   logic [CFG_W-1:0]   dim_reg [0:2];
   normal_word_t       normal_q [$];

   initial begin
      error_count     = 0;
      normals_pending = 0;
      foreach (voxel_mem[i]) voxel_mem[i] = '0;
   end

   function automatic int dim_eff(int ax);
      if (dim_reg[ax] == 0) return 1;
      if (dim_reg[ax] > 32) return 32;
      return int'(dim_reg[ax]);
   endfunction

   function automatic int clip(int c, int n);
      if (c < 0) return 0;
      if (c > n - 1) return n - 1;
      return c;
   endfunction

   function automatic longint voxel_rd(int c[3]);
      int a;
      a = clip(c[0], dim_eff(0)) + 32 * (clip(c[1], dim_eff(1)) + 32 * clip(c[2], dim_eff(2)));
      return longint'(voxel_mem[a]);
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res, bit_v;
      res   = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v   = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // separable sobel gradient, then scaled division by minus the norm
   function automatic normal_word_t sobel_normal(int p[3]);
      int          w[3];
      int          lo[3], hi[3];
      longint      g[3];
      logic [63:0] m[3], mx, s, r, n, t;
      logic [15:0] o[3];
      int          a1, a2, sh, k;
      normal_word_t res;
      w = '{1, 2, 1};
      mx = 0;
      for (int ax = 0; ax < 3; ax++) begin
         a1 = (ax + 1) % 3;
         a2 = (ax + 2) % 3;
         g[ax] = 0;
         for (int i = -1; i <= 1; i++) begin
            for (int j = -1; j <= 1; j++) begin
               lo = p;
               lo[a1] += i;
               lo[a2] += j;
               hi = lo;
               lo[ax] -= 1;
               hi[ax] += 1;
               g[ax] += w[i+1] * w[j+1] * (voxel_rd(lo) - voxel_rd(hi));
            end
         end
         // zero component forced to one lsb
         if (g[ax] == 0) g[ax] = 1;
         m[ax] = (g[ax] < 0) ? -g[ax] : g[ax];
         if (m[ax] > mx) mx = m[ax];
      end
      sh = 0;
      while ((mx >> sh) >= (64'd1 << 30)) sh++;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = m[i] >> sh;
         s += m[i] * m[i];
      end
      k = 0;
      while (k < K_MAX && s != 0) begin
         t = s << (2 * (k + 1));
         if ((t >> (2 * (k + 1))) != s || t >= (64'd1 << 62)) break;
         k++;
      end
      r = root_floor(s << (2 * k));
      for (int i = 0; i < 3; i++) begin
         if (r == 0) begin
            n = 0;
         end else begin
            n = ((m[i] << (FRAC_BITS + k)) + (r >> 1)) / r;
            if (n > NORM_ONE) n = NORM_ONE;
         end
         o[i] = (g[i] > 0) ? 16'(-n) : 16'(n);
      end
      res.nx = o[0];
      res.ny = o[1];
      res.nz = o[2];
      return res;
   endfunction

   always @(posedge clock) begin
      int           p[3];
      normal_word_t got, want;
      if (reset) begin
         dim_reg = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SIZE_X: dim_reg[0] = csr_wdata;
               CSR_SIZE_Y: dim_reg[1] = csr_wdata;
               CSR_SIZE_Z: dim_reg[2] = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            for (int i = 0; i < 3; i++)
               p[i] = clip(int'(req_tdata[5*i +: 5]), dim_eff(i));
            if (req_tuser == FUNC_LOAD)
               voxel_mem[p[0] + 32 * (p[1] + 32 * p[2])] = req_tdata[30:15];
            else
               normal_q = {normal_q, sobel_normal(p)};
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (normal_q.size() == 0) begin
               $display("%0t: normal word expected none actual %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = normal_q.pop_front();
               if (got.nx !== want.nx) begin
                  $display("%0t: normal_x expected %h actual %h", $time, want.nx, got.nx);
                  error_count++;
               end
               if (got.ny !== want.ny) begin
                  $display("%0t: normal_y expected %h actual %h", $time, want.ny, got.ny);
                  error_count++;
               end
               if (got.nz !== want.nz) begin
                  $display("%0t: normal_z expected %h actual %h", $time, want.nz, got.nz);
                  error_count++;
               end
            end
         end
         normals_pending = normal_q.size();
      end
   end

endmodule

[test/sobel_3d_volume_normals_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel 3d volume normals unit testbench
// drives voxel loads and normal requests under random idling on both sides,
// walks through several size settings; the checker predicts and compares
// ----------------------------------------------------------------------------
module sobel_3d_volume_normals_unit_tb;
   import sbn_pkg::*;

   // index past size_z, ignored by the block
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;
   logic                 req_tuser  = FUNC_LOAD;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [3*NORM_W-1:0]  rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]     csr_wdata  = '0;

   int   normals_pending;
   int   error_count;
   int   word_count  = 0;
   bit   quiet       = 0;      // no idling on either side
   bit   hold_rsp    = 0;      // ask the receiver for a long stall
   bit   stim_done   = 0;
   bit   loaded [0:32767];     // voxels written since reset
   int   dim_now [0:2];

   sobel_3d_volume_normals_unit dut (.*);

   sobel_3d_volume_normals_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("status: fail");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int clip(int c, int n);
      return (c > n - 1) ? n - 1 : c;
   endfunction

   // receiver: random stalls plus one long hold-off when asked
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            for (int c = 0; c < 600; c++) @(posedge clock);
            hold_rsp = 0;
         end
         n = idle_len();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_word(logic fn, int x, int y, int z, logic [15:0] v);
      int n;
      n = idle_len();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {1'b0, v, z[4:0], y[4:0], x[4:0]};
      do @(posedge clock); while (!req_tready);
      word_count++;
      if (fn == FUNC_LOAD)
         loaded[clip(x, dim_now[0]) + 32 * (clip(y, dim_now[1]) + 32 * clip(z, dim_now[2]))] = 1;
   endtask

   task automatic write_size(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b1;
      csr_index  <= idx;
      csr_wdata  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx != CSR_UNUSED)
         dim_now[idx] = (v == 0) ? 1 : ((v > 32) ? 32 : int'(v));
   endtask

   // wait for every normal, then out the longest compute before a register write
   task automatic drain();
      req_tvalid <= 1'b0;
      while (normals_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_value(int spread);
      case (spread)
         0: return 16'($urandom_range(0, 3));
         1: return 16'($urandom_range(0, 255) - 128);
         default: return 16'($urandom);
      endcase
   endfunction

   // fill any unwritten voxel of the clamped 3x3x3 neighborhood, then compute
   task automatic normal_at(int x, int y, int z, int spread);
      int cx, cy, cz;
      cx = clip(x, dim_now[0]);
      cy = clip(y, dim_now[1]);
      cz = clip(z, dim_now[2]);
      for (int dz = -1; dz <= 1; dz++)
         for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++) begin
               int ax, ay, az;
               ax = clip((cx + dx < 0) ? 0 : cx + dx, dim_now[0]);
               ay = clip((cy + dy < 0) ? 0 : cy + dy, dim_now[1]);
               az = clip((cz + dz < 0) ? 0 : cz + dz, dim_now[2]);
               if (!loaded[ax + 32 * (ay + 32 * az)])
                  send_word(FUNC_LOAD, ax, ay, az, rand_value(spread));
            end
      send_word(FUNC_NORMAL, x, y, z, 16'($urandom));
   endtask

   function automatic int rand_pos();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5);
   endfunction

   initial begin
      int sx, sy, sz;
      foreach (loaded[i]) loaded[i] = 0;
      dim_now = '{32, 32, 32};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme values, a flat region giving all-zero gradient
      write_size(CSR_SIZE_X, 6'd1);
      write_size(CSR_SIZE_Y, 6'd1);
      write_size(CSR_SIZE_Z, 6'd1);
      send_word(FUNC_LOAD, 0, 0, 0, 16'h8000);
      send_word(FUNC_NORMAL, 31, 31, 31, 16'hffff);     // clamps to the single voxel
      drain();
      write_size(CSR_SIZE_X, 6'd0);                     // zero size acts as one
      write_size(CSR_SIZE_Y, 6'd63);                    // above max acts as max
      write_size(CSR_SIZE_Z, 6'd2);
      write_size(CSR_UNUSED, 6'd5);
      send_word(FUNC_LOAD, 0, 0, 0, 16'h7fff);
      send_word(FUNC_LOAD, 0, 1, 0, 16'h8000);
      send_word(FUNC_LOAD, 0, 0, 1, 16'h8000);
      send_word(FUNC_LOAD, 0, 1, 1, 16'h7fff);
      normal_at(0, 0, 0, 2);
      normal_at(0, 31, 1, 0);
      normal_at(5, 30, 31, 1);
      drain();
      write_size(CSR_SIZE_X, 6'd32);
      write_size(CSR_SIZE_Y, 6'd32);
      write_size(CSR_SIZE_Z, 6'd32);
      normal_at(31, 31, 31, 2);
      normal_at(0, 0, 0, 0);
      normal_at(30, 30, 30, 1);

      // long receiver hold-off while requests keep coming
      quiet    = 1;
      hold_rsp = 1;
      for (int i = 0; i < 6; i++) normal_at(1, 1, 1, 1);
      quiet = 0;
      drain();

      // random phases over several size settings
      for (int ph = 0; word_count < 1050; ph++) begin
         case (ph % 4)
            0: begin sx = 32; sy = 32; sz = 32; end
            1: begin sx = 3; sy = 4; sz = 2; end
            2: begin sx = 1; sy = 32; sz = 5; end
            default: begin
               sx = $urandom_range(0, 63);
               sy = $urandom_range(0, 63);
               sz = $urandom_range(0, 63);
            end
         endcase
         write_size(CSR_SIZE_X, sx[5:0]);
         write_size(CSR_SIZE_Y, sy[5:0]);
         write_size(CSR_SIZE_Z, sz[5:0]);
         quiet = (ph % 5 == 3);
         for (int i = 0; i < 60 && word_count < 1050; i++) begin
            if ($urandom_range(0, 9) < 2)
               send_word(FUNC_LOAD, rand_pos(), rand_pos(), rand_pos(), rand_value(2));
            else
               normal_at(rand_pos(), rand_pos(), rand_pos(), $urandom_range(0, 2));
         end
         quiet = 0;
         drain();
      end

      while (normals_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/sbn_pkg.sv
rtl/sbn_ram.sv
rtl/sbn_csub.sv
rtl/sbn_norm.sv
rtl/sobel_3d_volume_normals_unit.sv
test/sobel_3d_volume_normals_checker.sv
test/sobel_3d_volume_normals_unit_tb.sv
